// ----- hdl/dsis_pkg.sv -----
// ----------------------------------------------------------------------------
// dsis_pkg: shared types and constants of the depth scale index selector
// Item structs, configuration register indexes, sequencer states and the
// fixed-point constants of the ratio and the scale table.
// ----------------------------------------------------------------------------
package dsis_pkg;

    localparam int MAX_SCALES = 32;
    localparam int FRAC_BITS  = 12;

    localparam int TABLE_CAP   = (MAX_SCALES < 32) ? MAX_SCALES : 32;
    localparam int UNITY_INT   = ((1 << FRAC_BITS) > 65535) ? 65535 : (1 << FRAC_BITS);
    localparam int DIVIDEND_W  = 16 + FRAC_BITS;
    localparam int ACC_W       = 21;
    localparam int DIST_W      = ACC_W + 1;

    localparam logic [15:0] UNITY_VALUE = 16'(UNITY_INT);
    localparam logic [5:0]  TABLE_MAX   = 6'(TABLE_CAP);

    localparam logic [15:0] RST_SCALE_START = 16'd1638;
    localparam logic [15:0] RST_SCALE_STEP  = 16'd410;
    localparam logic [5:0]  RST_SCALE_COUNT = 6'd19;
    localparam logic [15:0] RST_MIN_OFFSET  = 16'd410;
    localparam logic [4:0]  RST_UNITY_INDEX = 5'd6;
    localparam logic [4:0]  RST_INDEX       = 5'd6;
    localparam logic [15:0] RST_REFERENCE   = 16'd1;

    typedef enum logic [2:0] {
        CFG_SCALE_START = 3'd0,
        CFG_SCALE_STEP  = 3'd1,
        CFG_SCALE_COUNT = 3'd2,
        CFG_MIN_OFFSET  = 3'd3,
        CFG_UNITY_INDEX = 3'd4
    } cfg_index_t;

    typedef enum logic {
        OP_INIT   = 1'b0,
        OP_UPDATE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOCATE,
        ST_DECIDE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        op;
        logic [15:0] depth;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  scale_index;
        logic        scale_changed;
        logic [15:0] scale_value;
    } out_item_t;

endpackage

// ----- hdl/dsis_div.sv -----
// ----------------------------------------------------------------------------
// dsis_div: serial restoring divider
// One quotient bit per cycle; the quotient is saturated to 16 bits.
// ----------------------------------------------------------------------------
module dsis_div
    import dsis_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [15:0]           divisor,
    output logic                  done,
    output logic [15:0]           quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [16:0]           rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;

    logic [16:0] rem_shift;
    logic        q_bit;

    assign rem_shift = {rem_reg[15:0], quo_reg[DIVIDEND_W-1]};
    assign q_bit     = (rem_shift >= {1'b0, divisor});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = q_bit ? (rem_shift - {1'b0, divisor}) : rem_shift;
            quo_next = {quo_reg[DIVIDEND_W-2:0], q_bit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = (quo_reg[DIVIDEND_W-1:16] != '0) ? 16'hFFFF : quo_reg[15:0];

endmodule

// ----- hdl/depth_scale_index_selector.sv -----
// ----------------------------------------------------------------------------
// depth_scale_index_selector: depth-ratio scale index selector
// Keeps a reference depth and picks the table scale nearest the ratio
// reference/depth, searching only below or only above the current index.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one item per frame: an init
//   item latches the reference depth, an update item forms the ratio and may
//   move the index. Each item gives exactly one result on the out channel.
//   The config port (cfg_write/cfg_index/cfg_data) writes a register on any
//   clock edge with cfg_write high; write only while the block is idle.
// Sequence:
//   one item at a time; in_ready is low while an item is at work.
//   init: goes straight to the done state, which loads the result register.
//   update: serial divide (skipped on zero depth), then steps the shared
//   adder up to the current table scale, a decide step, a search over up
//   to table size scales and the output step.
// Reset: registers take their reset values, reference depth 1, ratio 1.0,
//   index 6; the block is ready at once.
// Stall: a result waits in the output register; the next item is accepted
//   and worked on, and its result waits until the output register is free.
// ----------------------------------------------------------------------------
module depth_scale_index_selector
    import dsis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    state_t state_reg, state_next;

    logic [15:0] scale_start_reg;
    logic [15:0] scale_step_reg;
    logic [5:0]  scale_count_reg;
    logic [15:0] min_offset_reg;
    logic [4:0]  unity_index_reg;

    logic [15:0]       ref_reg, ref_next;
    logic [15:0]       ratio_reg, ratio_next;
    logic [4:0]        cur_reg, cur_next;
    logic [15:0]       depth_reg, depth_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [5:0]        end_reg, end_next;
    logic [4:0]        best_idx_reg, best_idx_next;
    logic [DIST_W-1:0] best_d_reg, best_d_next;
    logic              first_reg, first_next;
    logic              changed_reg, changed_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic        div_start;
    logic        div_done;
    logic [15:0] div_quotient;

    logic [5:0]        tsize;
    logic [DIST_W-1:0] diff;
    logic              diff_neg;
    logic [DIST_W-1:0] dmag;
    logic              offset_big;
    logic              take;
    logic [4:0]        sel_idx;
    logic              scan_last;
    logic              in_xfer;
    logic              out_free;

    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign tsize = (scale_count_reg == '0) ? 6'd1
                 : ((scale_count_reg > TABLE_MAX) ? TABLE_MAX : scale_count_reg);

    // shared adder and compare: distance of the table scale from the ratio
    assign diff       = {1'b0, acc_reg} - {{(DIST_W-16){1'b0}}, ratio_reg};
    assign diff_neg   = diff[DIST_W-1];
    assign dmag       = diff_neg ? (~diff + 1'b1) : diff;
    assign offset_big = (dmag > {{(DIST_W-16){1'b0}}, min_offset_reg});
    assign take       = first_reg || (dmag <= best_d_reg);
    assign sel_idx    = take ? cnt_reg[4:0] : best_idx_reg;
    assign scan_last  = ((cnt_reg + 6'd1) == end_reg);

    assign div_start = in_xfer && (in_data.op == OP_UPDATE) && (in_data.depth != '0);

    dsis_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({ref_reg, {FRAC_BITS{1'b0}}}),
        .divisor  (depth_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_data.op == OP_INIT)
                        state_next = ST_DONE;
                    else if (in_data.depth != '0)
                        state_next = ST_DIV;
                    else
                        state_next = ST_LOCATE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_LOCATE;
            end
            ST_LOCATE:
            begin
                if (cnt_reg == {1'b0, cur_reg})
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (offset_big && ((!diff_neg && diff != '0 && cur_reg != '0)
                                   || (diff_neg && {1'b0, cur_reg} < tsize)))
                    state_next = ST_SEARCH;
                else
                    state_next = ST_DONE;
            end
            ST_SEARCH:
            begin
                if (scan_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ref_next       = ref_reg;
        ratio_next     = ratio_reg;
        cur_next       = cur_reg;
        depth_next     = depth_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        end_next       = end_reg;
        best_idx_next  = best_idx_reg;
        best_d_next    = best_d_reg;
        first_next     = first_reg;
        changed_next   = changed_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        in_ready       = (state_reg == ST_IDLE);

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    depth_next   = in_data.depth;
                    changed_next = 1'b0;
                    acc_next     = {{(ACC_W-16){1'b0}}, scale_start_reg};
                    cnt_next     = '0;
                    if (in_data.op == OP_INIT)
                    begin
                        ref_next     = in_data.depth;
                        ratio_next   = UNITY_VALUE;
                        cur_next     = ({1'b0, unity_index_reg} < tsize)
                                     ? unity_index_reg : 5'(tsize - 6'd1);
                        changed_next = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    ratio_next = div_quotient;
            end
            ST_LOCATE:
            begin
                if (cnt_reg != {1'b0, cur_reg})
                begin
                    acc_next = acc_reg + {{(ACC_W-16){1'b0}}, scale_step_reg};
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_DECIDE:
            begin
                first_next = 1'b1;
                if (!diff_neg && diff != '0 && cur_reg != '0)
                begin
                    // ratio below the current scale: scan from the bottom
                    acc_next = {{(ACC_W-16){1'b0}}, scale_start_reg};
                    cnt_next = '0;
                    end_next = ({1'b0, cur_reg} < tsize) ? {1'b0, cur_reg} : tsize;
                end
                else
                begin
                    // ratio above: scan from the current index upward
                    end_next = tsize;
                end
            end
            ST_SEARCH:
            begin
                if (take)
                begin
                    best_idx_next = cnt_reg[4:0];
                    best_d_next   = dmag;
                end
                first_next = 1'b0;
                acc_next   = acc_reg + {{(ACC_W-16){1'b0}}, scale_step_reg};
                cnt_next   = cnt_reg + 6'd1;
                if (scan_last && sel_idx != cur_reg)
                begin
                    cur_next     = sel_idx;
                    changed_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.scale_index   = cur_reg;
                    out_data_next.scale_changed = changed_reg;
                    out_data_next.scale_value   = ratio_reg;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_start_reg <= RST_SCALE_START;
            scale_step_reg  <= RST_SCALE_STEP;
            scale_count_reg <= RST_SCALE_COUNT;
            min_offset_reg  <= RST_MIN_OFFSET;
            unity_index_reg <= RST_UNITY_INDEX;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SCALE_START: scale_start_reg <= cfg_data;
                CFG_SCALE_STEP:  scale_step_reg  <= cfg_data;
                CFG_SCALE_COUNT: scale_count_reg <= cfg_data[5:0];
                CFG_MIN_OFFSET:  min_offset_reg  <= cfg_data;
                CFG_UNITY_INDEX: unity_index_reg <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ref_reg       <= RST_REFERENCE;
            ratio_reg     <= UNITY_VALUE;
            cur_reg       <= RST_INDEX;
            first_reg     <= 1'b1;
            changed_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ref_reg       <= ref_next;
            ratio_reg     <= ratio_next;
            cur_reg       <= cur_next;
            first_reg     <= first_next;
            changed_reg   <= changed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        depth_reg    <= depth_next;
        acc_reg      <= acc_next;
        cnt_reg      <= cnt_next;
        end_reg      <= end_next;
        best_idx_reg <= best_idx_next;
        best_d_reg   <= best_d_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
